>>> rtl/mcsp_pkg.sv
// Shared types and protocol constants for the memory card slave protocol engine.
// No dependencies; imported by memory_card_slave_protocol (mcsp_ram does not import it).
package mcsp_pkg;

  localparam int SECTOR_BYTES = 128;
  localparam int OFF_W        = 7;
  localparam int SECTOR_W     = 10;

  // item operations
  localparam logic [1:0] OP_XFER   = 2'd0;
  localparam logic [1:0] OP_DESEL  = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // command bytes
  localparam logic [7:0] CMD_NONE   = 8'h00;
  localparam logic [7:0] CMD_ACCESS = 8'h81;
  localparam logic [7:0] CMD_READ   = 8'h52;
  localparam logic [7:0] CMD_WRITE  = 8'h57;
  localparam logic [7:0] CMD_GETID  = 8'h53;
  localparam logic [7:0] CMD_GAMEID = 8'h21;
  localparam logic [7:0] CMD_PING   = 8'h20;

  // response bytes
  localparam logic [7:0] RSP_IDLE       = 8'hFF;
  localparam logic [7:0] RSP_ID1        = 8'h5A;
  localparam logic [7:0] RSP_ID2        = 8'h5D;
  localparam logic [7:0] RSP_DUMMY      = 8'h00;
  localparam logic [7:0] RSP_ACK1       = 8'h5C;
  localparam logic [7:0] RSP_ACK2       = 8'h5D;
  localparam logic [7:0] RSP_GOOD       = 8'h47;
  localparam logic [7:0] RSP_BAD_SUM    = 8'h4E;
  localparam logic [7:0] RSP_BAD_SECTOR = 8'hFF;
  localparam logic [7:0] RSP_PRESENT    = 8'h27;
  localparam logic [7:0] RSP_TERMINATE  = 8'hFF;
  localparam logic [7:0] FLAG_UNREAD    = 8'h08;
  localparam logic [7:0] FLAG_READ      = 8'h00;

  // read and write tick landmarks
  localparam logic [7:0] TICK_DATA_FIRST = 8'd8;
  localparam logic [7:0] TICK_DATA_LAST  = 8'd135;
  localparam logic [7:0] TICK_RD_SUM     = 8'd136;
  localparam logic [7:0] TICK_RD_END     = 8'd137;
  localparam logic [7:0] TICK_WR_LAST    = 8'd132;
  localparam logic [7:0] TICK_WR_SUM     = 8'd133;
  localparam logic [7:0] TICK_WR_ACK2    = 8'd134;
  localparam logic [7:0] TICK_WR_OFFSET  = 8'd5;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]          tx_byte;
    logic                committed;
    logic [SECTOR_W-1:0] committed_sector;
  } out_item_t;

endpackage

>>> rtl/mcsp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; used for the card memory and the write buffer.
module mcsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/memory_card_slave_protocol.sv
// Memory card slave protocol engine: top level with command decoder and sequencer.
// Depends on mcsp_pkg and mcsp_ram (card memory and write buffer).
//
// Slave side of a byte-exchange memory card link. Each input transfer carries one
// host byte (or a deselect or commit) and yields exactly one result transfer with
// the answered byte. The card memory read is issued as the transfer is taken and
// its registered data is used in the next cycle. A commit of a pending in-range
// sector copies the 128-byte write buffer into card memory through the one write
// port. After reset the card memory is swept to zero one byte per cycle, during
// which no transfer is taken. A finished result sits in an output register, so
// the next transfer can be taken while it waits.
module memory_card_slave_protocol #(
  parameter int SECTOR_COUNT = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mcsp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mcsp_pkg::out_item_t out_data_o
);

  import mcsp_pkg::*;

  localparam int MEM_DEPTH = SECTOR_COUNT * SECTOR_BYTES;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);
  localparam int SW        = MEM_AW - OFF_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DONE
  } state_e;

  state_e      state_q;
  in_item_t    item_q;
  out_item_t   out_q;
  logic        out_valid_q;
  logic [MEM_AW-1:0] clr_q;
  logic [OFF_W:0]    cp_cnt_q;

  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  tick_q, tick_d;
  logic [15:0] sector_q, sector_d;
  logic [OFF_W-1:0] roff_q, roff_d;
  logic [7:0]  hsum_q, hsum_d;
  logic [7:0]  rsum_q, rsum_d;
  logic        unread_q, unread_d;
  logic        wpend_q, wpend_d;
  logic [7:0]  idlen_q, idlen_d;

  logic [7:0]  tx;
  logic        go_copy;
  logic        buf_we;
  logic        out_free;
  logic        out_load;
  logic        in_xfer;
  logic        sec_ok;
  logic [7:0]  flag;
  logic [7:0]  card_rdata;
  logic [7:0]  buf_rdata;
  logic        card_we;
  logic [MEM_AW-1:0] card_waddr;
  logic [MEM_AW-1:0] card_raddr;
  logic [OFF_W-1:0]  buf_waddr;
  logic [OFF_W-1:0]  copy_off;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = out_free && (((state_q == ST_EXEC) && !go_copy) ||
                                    (state_q == ST_DONE));
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign sec_ok      = (sector_q < 16'(SECTOR_COUNT));
  assign flag        = unread_q ? FLAG_UNREAD : FLAG_READ;

  // card memory: sweep, commit copy, and streaming reads
  assign copy_off   = OFF_W'(cp_cnt_q - 1'b1);
  assign card_we    = (state_q == ST_CLEAR) || ((state_q == ST_COPY) && (cp_cnt_q != '0));
  assign card_waddr = (state_q == ST_CLEAR) ? clr_q : {sector_q[SW-1:0], copy_off};
  assign card_raddr = {sector_q[SW-1:0], roff_q};

  mcsp_ram #(
    .WIDTH(8),
    .DEPTH(MEM_DEPTH)
  ) u_card_mem (
    .clk_i  (clk_i),
    .we_i   (card_we),
    .waddr_i(card_waddr),
    .wdata_i((state_q == ST_CLEAR) ? 8'h00 : buf_rdata),
    .re_i   (in_xfer),
    .raddr_i(card_raddr),
    .rdata_o(card_rdata)
  );

  assign buf_waddr = OFF_W'(tick_q - TICK_WR_OFFSET);

  mcsp_ram #(
    .WIDTH(8),
    .DEPTH(SECTOR_BYTES)
  ) u_wr_buf (
    .clk_i  (clk_i),
    .we_i   (buf_we && (state_q == ST_EXEC) && out_free),
    .waddr_i(buf_waddr),
    .wdata_i(item_q.rx_byte),
    .re_i   ((state_q == ST_COPY) && !cp_cnt_q[OFF_W]),
    .raddr_i(cp_cnt_q[OFF_W-1:0]),
    .rdata_o(buf_rdata)
  );

  // protocol decode for the item held in item_q
  always_comb begin
    logic [7:0] c;
    logic [7:0] rx;
    logic [7:0] rd_byte;
    logic [15:0] sec_new;
    logic       handled;
    logic       bump;

    c        = cmd_q;
    rx       = item_q.rx_byte;
    rd_byte  = sec_ok ? card_rdata : 8'h00;
    sec_new  = sector_q | {8'h00, rx};
    handled  = 1'b0;
    bump     = 1'b0;
    cmd_d    = cmd_q;
    tick_d   = tick_q;
    sector_d = sector_q;
    roff_d   = roff_q;
    hsum_d   = hsum_q;
    rsum_d   = rsum_q;
    unread_d = unread_q;
    wpend_d  = wpend_q;
    idlen_d  = idlen_q;
    tx       = RSP_IDLE;
    go_copy  = 1'b0;
    buf_we   = 1'b0;

    unique case (item_q.op)
      OP_XFER: begin
        if (c == CMD_ACCESS) begin
          if (rx == CMD_READ || rx == CMD_WRITE || rx == CMD_GETID ||
              rx == CMD_GAMEID || rx == CMD_PING) begin
            cmd_d = rx;
            c     = rx;
          end else begin
            // unknown sub-command restarts as a fresh command byte
            tick_d  = '0;
            roff_d  = '0;
            cmd_d   = rx;
            tx      = flag;
            handled = 1'b1;
          end
        end
        if (!handled) begin
          unique case (c)
            CMD_NONE: begin
              cmd_d = rx;
              tx    = flag;
            end
            CMD_READ: begin
              bump = 1'b1;
              priority if (tick_q == 8'd0) tx = RSP_ID1;
              else if (tick_q == 8'd1) tx = RSP_ID2;
              else if (tick_q == 8'd2) tx = RSP_DUMMY;
              else if (tick_q == 8'd3) begin
                sector_d = {rx, 8'h00};
                tx       = rx;
              end else if (tick_q == 8'd4) begin
                sector_d = sec_new;
                tx       = RSP_ACK1;
              end else if (tick_q == 8'd5) tx = RSP_ACK2;
              else if (tick_q == 8'd6) tx = sector_q[15:8];
              else if (tick_q == 8'd7) begin
                tx     = sector_q[7:0];
                rsum_d = sector_q[15:8] ^ sector_q[7:0];
              end else if (tick_q == TICK_RD_SUM) tx = rsum_q;
              else if (tick_q == TICK_RD_END) tx = RSP_GOOD;
              else if (tick_q >= TICK_DATA_FIRST && tick_q <= TICK_DATA_LAST) begin
                tx     = rd_byte;
                rsum_d = rsum_q ^ rd_byte;
                roff_d = roff_q + 1'b1;
              end else tx = RSP_ACK1;
            end
            CMD_WRITE: begin
              bump = 1'b1;
              priority if (tick_q == 8'd0) tx = RSP_ID1;
              else if (tick_q == 8'd1) tx = RSP_ID2;
              else if (tick_q == 8'd2) tx = RSP_DUMMY;
              else if (tick_q == 8'd3) begin
                sector_d = {rx, 8'h00};
                tx       = rx;
              end else if (tick_q == 8'd4) begin
                sector_d = sec_new;
                rsum_d   = sec_new[15:8] ^ sec_new[7:0];
                tx       = rx;
              end else if (tick_q <= TICK_WR_LAST) begin
                buf_we = 1'b1;
                rsum_d = rsum_q ^ rx;
                tx     = rx;
              end else if (tick_q == TICK_WR_SUM) begin
                hsum_d = rx;
                tx     = RSP_ACK1;
              end else if (tick_q == TICK_WR_ACK2) tx = RSP_ACK2;
              else begin
                // end of write: status byte, back to idle with tick at zero
                bump = 1'b0;
                if (!sec_ok) tx = RSP_BAD_SECTOR;
                else if (hsum_q == rsum_q) begin
                  unread_d = 1'b0;
                  wpend_d  = 1'b1;
                  tx       = RSP_GOOD;
                end else tx = RSP_BAD_SUM;
                cmd_d  = CMD_NONE;
                tick_d = '0;
                roff_d = '0;
              end
            end
            CMD_GAMEID: begin
              bump = 1'b1;
              priority if (tick_q <= 8'd1) tx = RSP_DUMMY;
              else if (tick_q == 8'd2) begin
                idlen_d = rx;
                tx      = RSP_DUMMY;
              end else if ((tick_q - 8'd3) <= idlen_q) tx = RSP_DUMMY;
              else tx = RSP_ACK1;
            end
            CMD_PING: begin
              bump = 1'b1;
              priority if (tick_q <= 8'd2) tx = RSP_DUMMY;
              else if (tick_q == 8'd3) tx = RSP_PRESENT;
              else if (tick_q == 8'd4) tx = RSP_TERMINATE;
              else tx = RSP_ACK1;
            end
            default: begin
              cmd_d  = CMD_NONE;
              tick_d = '0;
              roff_d = '0;
              tx     = RSP_IDLE;
            end
          endcase
        end
        if (bump && tick_q != 8'hFF) begin
          tick_d = tick_q + 1'b1;
        end
      end
      OP_DESEL: begin
        cmd_d  = CMD_NONE;
        tick_d = '0;
        roff_d = '0;
      end
      OP_COMMIT: begin
        if (wpend_q) begin
          if (sec_ok) go_copy = 1'b1;
          else wpend_d = 1'b0;
        end
      end
      OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      cp_cnt_q    <= '0;
      cmd_q       <= CMD_NONE;
      tick_q      <= '0;
      sector_q    <= '0;
      roff_q      <= '0;
      hsum_q      <= '0;
      rsum_q      <= '0;
      unread_q    <= 1'b1;
      wpend_q     <= 1'b0;
      idlen_q     <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == MEM_AW'(MEM_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
          clr_q <= clr_q + 1'b1;
        end
        ST_IDLE: begin
          if (in_xfer) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (go_copy) begin
            cp_cnt_q <= '0;
            state_q  <= ST_COPY;
          end else if (out_free) begin
            cmd_q       <= cmd_d;
            tick_q      <= tick_d;
            sector_q    <= sector_d;
            roff_q      <= roff_d;
            hsum_q      <= hsum_d;
            rsum_q      <= rsum_d;
            unread_q    <= unread_d;
            wpend_q     <= wpend_d;
            idlen_q     <= idlen_d;
            state_q     <= ST_IDLE;
          end
        end
        ST_COPY: begin
          // buffer read runs one entry ahead of the card write
          if (cp_cnt_q[OFF_W]) begin
            state_q <= ST_DONE;
          end
          cp_cnt_q <= cp_cnt_q + 1'b1;
        end
        ST_DONE: begin
          if (out_free) begin
            wpend_q     <= 1'b0;
            if (sector_q == 16'h0000) begin
              unread_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // result payload and accepted item, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_EXEC && !go_copy && out_free) begin
      out_q <= '{tx_byte: tx, committed: 1'b0, committed_sector: '0};
    end else if (state_q == ST_DONE && out_free) begin
      out_q <= '{tx_byte: RSP_IDLE, committed: 1'b1,
                 committed_sector: sector_q[SECTOR_W-1:0]};
    end
  end

endmodule
